// ----- rtl/mpi_pkg.sv -----
// mpi_pkg: shared constants, types and helpers of the pixel iterator
// used by mpi_csr, mandelbrot_pixel_iterator_core and mpi_check
`default_nettype none

package mpi_pkg;

   // iteration limit and fixed-point format
   localparam int MAX_ITER  = 128;
   localparam int FRAC_BITS = 28;
   localparam int CNT_W     = $clog2(MAX_ITER + 1);
   localparam int WIDE_W    = 50;
   localparam int BLUE_MAX  = 255;

   // field widths
   localparam int PX_W     = 12;
   localparam int COORD_W  = 32;
   localparam int STEP_W   = 31;
   localparam int RED_W    = 8;
   localparam int COLOR_W  = 32;
   localparam int ITER_W   = 8;
   localparam int MUL_W    = 33;
   localparam int PROD_W   = 64;
   localparam int MAP_W    = PX_W + STEP_W;
   localparam int ADDR_W   = 5;
   localparam int DATA_W   = 32;
   localparam int REQ_W    = 24;
   localparam int RSP_W    = 40;

   // reset values of the configuration registers
   localparam logic signed [COORD_W-1:0] MIN_REAL_RST  = -32'sd669382196;
   localparam logic [STEP_W-1:0]         REAL_STEP_RST = 31'd918402;
   localparam logic signed [COORD_W-1:0] MAX_IMAG_RST  = 32'sd303821960;
   localparam logic [STEP_W-1:0]         IMAG_STEP_RST = 31'd699962;
   localparam logic [RED_W-1:0]          RED_LEVEL_RST = 8'd0;

   // register indexes (byte address / 4)
   typedef enum logic [2:0] {
      REG_MIN_REAL  = 3'd0,
      REG_REAL_STEP = 3'd1,
      REG_MAX_IMAG  = 3'd2,
      REG_IMAG_STEP = 3'd3,
      REG_RED_LEVEL = 3'd4
   } reg_index_type;

   // configuration seen by the datapath
   typedef struct packed {
      logic signed [COORD_W-1:0] min_real;
      logic [STEP_W-1:0]         real_step;
      logic signed [COORD_W-1:0] max_imag;
      logic [STEP_W-1:0]         imag_step;
      logic [RED_W-1:0]          red_level;
   } cfg_type;

   // clamp a wide signed value to the signed 32-bit range
   function automatic logic signed [COORD_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = WIDE_W'(32'sh7fffffff);
      lo = -hi - WIDE_W'(1);
      if (v > hi) begin
         return COORD_W'(hi);
      end else if (v < lo) begin
         return COORD_W'(lo);
      end
      return COORD_W'(v);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/mandelbrot_pixel_iterator_core.sv -----
// mandelbrot_pixel_iterator_core: escape-time iterator for one pixel at a time
// depends on mpi_pkg and mpi_csr
//
//  channel | dir | handshake              | payload
//  req     | in  | req_tvalid/req_tready  | px, py
//  rsp     | out | rsp_tvalid/rsp_tready  | pixel_color, iter_count
//  csr     | in  | psel/penable/pwrite    | 5 registers at byte address 4*i
//
// the block is ready again in the cycle after the hand-off; the single 33x33
// multiplier serves the mapping and all three products of each iteration,
// which steps through ST_SQ_RE, ST_SQ_IM, ST_CROSS and ST_UPDATE.
// reset is synchronous and clears the sequencer and the output valid.
// a result waiting in the output register does not block a new item; only the
// hand-off of the next result waits for the output register to drain.
`default_nettype none

module mandelbrot_pixel_iterator_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // input items; tdata = {py, px}, px in bits 11:0, py in bits 23:12
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [mpi_pkg::REQ_W-1:0]   req_tdata,
   // result items; tdata = {iter_count, pixel_color}, colour in 31:0, count in 39:32
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic      [mpi_pkg::RSP_W-1:0]   rsp_tdata,
   // configuration port
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [mpi_pkg::ADDR_W-1:0]  csr_paddr,
   input  wire logic [mpi_pkg::DATA_W-1:0]  csr_pwdata,
   output logic      [mpi_pkg::DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_MAP_X  = 9'b000000010,
      ST_MAP_Y  = 9'b000000100,
      ST_MAP_C  = 9'b000001000,
      ST_SQ_RE  = 9'b000010000,
      ST_SQ_IM  = 9'b000100000,
      ST_CROSS  = 9'b001000000,
      ST_UPDATE = 9'b010000000,
      ST_DRAIN  = 9'b100000000
   } state_type;

   localparam int CW = mpi_pkg::COORD_W;
   localparam int FB = mpi_pkg::FRAC_BITS;
   localparam int WW = mpi_pkg::WIDE_W;
   localparam int NW = mpi_pkg::CNT_W;

   mpi_pkg::cfg_type cfg;

   state_type                          state_ff, state_in;
   logic [mpi_pkg::PX_W-1:0]           px_ff, px_in, py_ff, py_in;
   logic signed [CW-1:0]               cr_ff, cr_in, ci_ff, ci_in;
   logic signed [CW-1:0]               zr_ff, zr_in, zi_ff, zi_in;
   logic signed [mpi_pkg::PROD_W-1:0]  prod_ff, prod_in, acc_ff, acc_in;
   logic                               esc_ff, esc_in;
   logic [NW-1:0]                      n_ff, n_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [mpi_pkg::COLOR_W-1:0]        color_ff, color_in;
   logic [mpi_pkg::ITER_W-1:0]         iter_ff, iter_in;

   logic signed [mpi_pkg::MUL_W-1:0]   mul_a, mul_b;
   logic signed [2*mpi_pkg::MUL_W-1:0] mul_full;
   logic [mpi_pkg::MAP_W-1:0]          map_prod;
   logic [mpi_pkg::PROD_W:0]           mag_sum;
   logic signed [mpi_pkg::PROD_W-FB-1:0] re_shift;
   logic signed [mpi_pkg::PROD_W-FB:0] im_shift;
   logic signed [CW-1:0]               nr, ni;
   logic [NW+7:0]                      blue_num;
   logic [7:0]                         blue;
   logic                               out_free;

   mpi_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MAP_X: begin
            mul_a = mpi_pkg::MUL_W'(px_ff);
            mul_b = mpi_pkg::MUL_W'(cfg.real_step);
         end
         ST_MAP_Y: begin
            mul_a = mpi_pkg::MUL_W'(py_ff);
            mul_b = mpi_pkg::MUL_W'(cfg.imag_step);
         end
         ST_SQ_RE: begin
            mul_a = mpi_pkg::MUL_W'(zr_ff);
            mul_b = mpi_pkg::MUL_W'(zr_ff);
         end
         ST_SQ_IM: begin
            mul_a = mpi_pkg::MUL_W'(zi_ff);
            mul_b = mpi_pkg::MUL_W'(zi_ff);
         end
         ST_CROSS: begin
            mul_a = mpi_pkg::MUL_W'(zr_ff);
            mul_b = mpi_pkg::MUL_W'(zi_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_full = mul_a * mul_b;
   assign prod_in  = mul_full[mpi_pkg::PROD_W-1:0];
   assign map_prod = prod_ff[mpi_pkg::MAP_W-1:0];

   // escape test: |z|^2 > 4 in the squared fixed-point scale
   assign mag_sum = {1'b0, acc_ff} + {1'b0, prod_ff};

   // next z from the stored products, floored and clamped
   assign re_shift = acc_ff[mpi_pkg::PROD_W-1:FB];
   assign im_shift = prod_ff[mpi_pkg::PROD_W-1:FB-1];
   assign nr = mpi_pkg::sat32(WW'(re_shift) + WW'(cr_ff));
   assign ni = mpi_pkg::sat32(WW'(im_shift) + WW'(ci_ff));

   // blue channel from the iteration count
   assign blue_num = (NW + 8)'(n_ff) * (NW + 8)'(mpi_pkg::BLUE_MAX);
   assign blue     = 8'(blue_num / mpi_pkg::MAX_ITER);
   assign out_free = !rsp_valid_ff || rsp_tready;

   // sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      cr_in        = cr_ff;
      ci_in        = ci_ff;
      zr_in        = zr_ff;
      zi_in        = zi_ff;
      acc_in       = acc_ff;
      esc_in       = esc_ff;
      n_in         = n_ff;
      color_in     = color_ff;
      iter_in      = iter_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               px_in    = req_tdata[mpi_pkg::PX_W-1:0];
               py_in    = req_tdata[2*mpi_pkg::PX_W-1:mpi_pkg::PX_W];
               n_in     = '0;
               state_in = ST_MAP_X;
            end
         end
         ST_MAP_X: state_in = ST_MAP_Y;
         ST_MAP_Y: begin
            cr_in    = mpi_pkg::sat32(WW'(cfg.min_real) + WW'(map_prod));
            state_in = ST_MAP_C;
         end
         ST_MAP_C: begin
            ci_in    = mpi_pkg::sat32(WW'(cfg.max_imag) - WW'(map_prod));
            zi_in    = ci_in;
            zr_in    = cr_ff;
            state_in = ST_SQ_RE;
         end
         ST_SQ_RE: state_in = ST_SQ_IM;
         ST_SQ_IM: begin
            acc_in   = prod_ff;
            state_in = ST_CROSS;
         end
         ST_CROSS: begin
            esc_in   = mag_sum > ((mpi_pkg::PROD_W + 1)'(1) << (2 * FB + 2));
            acc_in   = acc_ff - prod_ff;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (esc_ff) begin
               state_in = ST_DRAIN;
            end else begin
               zr_in = nr;
               zi_in = ni;
               n_in  = n_ff + NW'(1);
               if (n_in == NW'(mpi_pkg::MAX_ITER)) begin
                  state_in = ST_DRAIN;
               end else begin
                  state_in = ST_SQ_RE;
               end
            end
         end
         ST_DRAIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               iter_in      = mpi_pkg::ITER_W'(n_ff);
               if (n_ff < NW'(mpi_pkg::MAX_ITER)) begin
                  color_in = {8'd0, cfg.red_level, blue, 8'hff};
               end else begin
                  color_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      px_ff    <= px_in;
      py_ff    <= py_in;
      cr_ff    <= cr_in;
      ci_ff    <= ci_in;
      zr_ff    <= zr_in;
      zi_ff    <= zi_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      esc_ff   <= esc_in;
      n_ff     <= n_in;
      color_ff <= color_in;
      iter_ff  <= iter_in;
   end

   // no item is taken while reset is held
   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {iter_ff, color_ff};

endmodule

`default_nettype wire

// ----- rtl/mpi_csr.sv -----
// mpi_csr: configuration register file behind the bus port
// depends on mpi_pkg for register indexes, reset values and cfg_type
`default_nettype none

module mpi_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [mpi_pkg::ADDR_W-1:0]   paddr,
   input  wire logic [mpi_pkg::DATA_W-1:0]   pwdata,
   output logic      [mpi_pkg::DATA_W-1:0]   prdata,
   output logic                              pready,
   output mpi_pkg::cfg_type                  cfg
);

   mpi_pkg::cfg_type      cfg_ff;
   mpi_pkg::cfg_type      cfg_in;
   mpi_pkg::reg_index_type idx;
   logic                  wr_en;

   assign pready = 1'b1;
   assign idx    = mpi_pkg::reg_index_type'(paddr[mpi_pkg::ADDR_W-1:2]);
   assign wr_en  = psel && penable && pwrite;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            mpi_pkg::REG_MIN_REAL:  cfg_in.min_real  = pwdata;
            mpi_pkg::REG_REAL_STEP: cfg_in.real_step = pwdata[mpi_pkg::STEP_W-1:0];
            mpi_pkg::REG_MAX_IMAG:  cfg_in.max_imag  = pwdata;
            mpi_pkg::REG_IMAG_STEP: cfg_in.imag_step = pwdata[mpi_pkg::STEP_W-1:0];
            mpi_pkg::REG_RED_LEVEL: cfg_in.red_level = pwdata[mpi_pkg::RED_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_real  <= mpi_pkg::MIN_REAL_RST;
         cfg_ff.real_step <= mpi_pkg::REAL_STEP_RST;
         cfg_ff.max_imag  <= mpi_pkg::MAX_IMAG_RST;
         cfg_ff.imag_step <= mpi_pkg::IMAG_STEP_RST;
         cfg_ff.red_level <= mpi_pkg::RED_LEVEL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read-back mux
   always_comb begin
      unique case (idx)
         mpi_pkg::REG_MIN_REAL:  prdata = cfg_ff.min_real;
         mpi_pkg::REG_REAL_STEP: prdata = mpi_pkg::DATA_W'(cfg_ff.real_step);
         mpi_pkg::REG_MAX_IMAG:  prdata = cfg_ff.max_imag;
         mpi_pkg::REG_IMAG_STEP: prdata = mpi_pkg::DATA_W'(cfg_ff.imag_step);
         mpi_pkg::REG_RED_LEVEL: prdata = mpi_pkg::DATA_W'(cfg_ff.red_level);
         default: prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- rtl/mpi_check.sv -----
// mpi_check: port-level checks of the pixel iterator, bound to the top level
// depends on mpi_pkg and mandelbrot_pixel_iterator_core
`default_nettype none

module mpi_check (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_tvalid,
   input wire logic                       req_tready,
   input wire logic                       rsp_tvalid,
   input wire logic                       rsp_tready,
   input wire logic [mpi_pkg::RSP_W-1:0]  rsp_tdata
);

   // output is empty straight after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // one item at a time: busy after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted while busy");

   // count never above the limit, and a pixel at the limit is black
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[39:32] <= 8'(mpi_pkg::MAX_ITER))
      else $error("iteration count above limit");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[39:32] == 8'(mpi_pkg::MAX_ITER)) == (rsp_tdata[31:0] == 32'd0))
      else $error("colour does not match iteration count");

endmodule

bind mandelbrot_pixel_iterator_core mpi_check u_mpi_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ----- test/mandelbrot_pixel_iterator_core_tb.sv -----
// mandelbrot_pixel_iterator_core_tb: self-checking bench for the escape-time pixel iterator
// sends pixels on req, checks colour and count on rsp, programs the viewport over csr
// depends on mpi_pkg and mandelbrot_pixel_iterator_core

module mandelbrot_pixel_iterator_core_tb;

   localparam int CLOCK_HALF   = 2;
   localparam int RESET_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 4000000;
   // margin for the longest pixel plus the output hand-off
   localparam int DRAIN_CYCLES = 4 * mpi_pkg::MAX_ITER + 16;
   localparam int HOLD_CYCLES  = 3000;
   localparam int VIEW_PIXELS  = 90;
   localparam int VIEW_KINDS   = 3;
   localparam int SPARE_REG    = 5;   // first index past the register list
   localparam int LAST_INDEX   = 7;   // highest index the address port can name
   localparam int HALF_SPAN    = 1 << (mpi_pkg::PX_W - 1);
   localparam logic [63:0] ESCAPE_MAG = 64'd4 << (2 * mpi_pkg::FRAC_BITS);
   // zoom target near the seahorse valley, Q4.28
   localparam int ZOOM_RE = -199620148;
   localparam int ZOOM_IM = 35386504;

   // writable bits of each register, in register order
   localparam logic [mpi_pkg::DATA_W-1:0] REG_MASK [SPARE_REG] =
      '{32'hffffffff, 32'h7fffffff, 32'hffffffff, 32'h7fffffff, 32'h000000ff};

   typedef struct packed {
      logic [mpi_pkg::COLOR_W-1:0] color;
      logic [mpi_pkg::ITER_W-1:0]  count;
   } pixel_result_type;

   typedef enum int {
      VIEW_WHOLE,
      VIEW_ZOOM,
      VIEW_ANY
   } view_kind_type;

   logic                         clock       = 1'b0;
   logic                         reset       = 1'b1;
   logic                         req_tvalid  = 1'b0;
   logic                         req_tready;
   logic [mpi_pkg::REQ_W-1:0]    req_tdata   = '0;   // px [11:0], py [23:12]
   logic                         rsp_tvalid;
   logic                         rsp_tready  = 1'b0;
   logic [mpi_pkg::RSP_W-1:0]    rsp_tdata;          // pixel_color [31:0], iter_count [39:32]
   logic                         csr_psel    = 1'b0;
   logic                         csr_penable = 1'b0;
   logic                         csr_pwrite  = 1'b0;
   logic [mpi_pkg::ADDR_W-1:0]   csr_paddr   = '0;
   logic [mpi_pkg::DATA_W-1:0]   csr_pwdata  = '0;
   logic [mpi_pkg::DATA_W-1:0]   csr_prdata;
   logic                         csr_pready;

   // viewport as the block should hold it
   logic [mpi_pkg::DATA_W-1:0] view_regs [SPARE_REG] =
      '{mpi_pkg::MIN_REAL_RST, mpi_pkg::DATA_W'(mpi_pkg::REAL_STEP_RST),
        mpi_pkg::MAX_IMAG_RST, mpi_pkg::DATA_W'(mpi_pkg::IMAG_STEP_RST),
        mpi_pkg::DATA_W'(mpi_pkg::RED_LEVEL_RST)};

   pixel_result_type awaited_pixels [$];
   int unsigned      send_idle_pct  = 0;
   int unsigned      rsp_stall_pct  = 0;
   int unsigned      mismatch_count = 0;
   int unsigned      cycle_count    = 0;
   logic             rsp_holding    = 1'b0;
   event             hold_rsp_start;

   mandelbrot_pixel_iterator_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #CLOCK_HALF clock = ~clock;

   // run-length guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // clamp to the signed 32-bit range
   function automatic longint clamp_q428(input longint v);
      if (v > 64'sd2147483647) begin
         return 64'sd2147483647;
      end else if (v < -64'sd2147483648) begin
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // escape-time colour and count of one pixel under the current viewport
   function automatic pixel_result_type trace_pixel(input logic [mpi_pkg::PX_W-1:0] px,
                                                    input logic [mpi_pkg::PX_W-1:0] py);
      longint           c_re;
      longint           c_im;
      longint           z_re;
      longint           z_im;
      longint           next_re;
      logic [63:0]      mag;
      int unsigned      n;
      logic [7:0]       blue;
      pixel_result_type res;
      c_re = clamp_q428(longint'($signed(view_regs[mpi_pkg::REG_MIN_REAL]))
                        + longint'(px) * longint'(view_regs[mpi_pkg::REG_REAL_STEP]));
      c_im = clamp_q428(longint'($signed(view_regs[mpi_pkg::REG_MAX_IMAG]))
                        - longint'(py) * longint'(view_regs[mpi_pkg::REG_IMAG_STEP]));
      z_re = c_re;
      z_im = c_im;
      n = 0;
      forever begin
         mag = $unsigned(z_re * z_re) + $unsigned(z_im * z_im);
         if (n == mpi_pkg::MAX_ITER || mag > ESCAPE_MAG) break;
         // floor division by the fraction scale is an arithmetic shift
         next_re = clamp_q428(((z_re * z_re - z_im * z_im) >>> mpi_pkg::FRAC_BITS) + c_re);
         z_im = clamp_q428(((z_re * z_im) >>> (mpi_pkg::FRAC_BITS - 1)) + c_im);
         z_re = next_re;
         n++;
      end
      blue = 8'(n * mpi_pkg::BLUE_MAX / mpi_pkg::MAX_ITER);
      res.count = mpi_pkg::ITER_W'(n);
      res.color = (n < mpi_pkg::MAX_ITER) ?
                  {8'h00, view_regs[mpi_pkg::REG_RED_LEVEL][mpi_pkg::RED_W-1:0], blue, 8'hff}
                  : '0;
      return res;
   endfunction

   // result side: check each item, then pick readiness for the next edge
   always @(posedge clock) begin : rsp_side
      pixel_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_pixels.size() == 0) begin
            $display("%0t unexpected result item: expected none actual %h", $time, rsp_tdata);
            mismatch_count++;
         end else begin
            want = awaited_pixels.pop_front();
            if (rsp_tdata[mpi_pkg::COLOR_W-1:0] !== want.color) begin
               $display("%0t pixel_color mismatch: expected %h actual %h",
                        $time, want.color, rsp_tdata[mpi_pkg::COLOR_W-1:0]);
               mismatch_count++;
            end
            if (rsp_tdata[mpi_pkg::COLOR_W +: mpi_pkg::ITER_W] !== want.count) begin
               $display("%0t iter_count mismatch: expected %0d actual %0d",
                        $time, want.count, rsp_tdata[mpi_pkg::COLOR_W +: mpi_pkg::ITER_W]);
               mismatch_count++;
            end
         end
      end
      if (rsp_holding) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // long receiver hold-off, counted here
   initial forever begin
      @(hold_rsp_start);
      rsp_holding = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_holding = 1'b0;
   end

   // offer one pixel, with random idle cycles ahead of it
   task automatic send_pixel(input logic [mpi_pkg::PX_W-1:0] px,
                             input logic [mpi_pkg::PX_W-1:0] py);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {py, px};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      awaited_pixels.push_back(trace_pixel(px, py));
   endtask

   // stop offering and wait for every result
   task automatic drain_pixels();
      req_tvalid <= 1'b0;
      while (awaited_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // one register access: setup, access, then an idle cycle
   task automatic csr_cycle(input logic is_write, input int unsigned index,
                            input logic [mpi_pkg::DATA_W-1:0] wdata,
                            output logic [mpi_pkg::DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= mpi_pkg::ADDR_W'(index * 4);
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_reg(input int unsigned index);
      logic [mpi_pkg::DATA_W-1:0] readback;
      csr_cycle(1'b0, index, '0, readback);
      if (readback !== view_regs[index]) begin
         $display("%0t register %0d readback mismatch: expected %h actual %h",
                  $time, index, view_regs[index], readback);
         mismatch_count++;
      end
   endtask

   // write; for a listed register, track the writable bits and read back
   task automatic set_reg(input int unsigned index, input logic [mpi_pkg::DATA_W-1:0] value);
      logic [mpi_pkg::DATA_W-1:0] ignored;
      csr_cycle(1'b1, index, value, ignored);
      if (index < SPARE_REG) begin
         view_regs[index] = value & REG_MASK[index];
         check_reg(index);
      end
   endtask

   function automatic logic [mpi_pkg::DATA_W-1:0] extreme_or_random();
      case ($urandom_range(3))
         0:       return 32'h80000000;
         1:       return 32'h7fffffff;
         default: return $urandom();
      endcase
   endfunction

   // choose and program a viewport of the given kind
   task automatic pick_view(input view_kind_type kind);
      int                         centre_re;
      int                         centre_im;
      logic [mpi_pkg::DATA_W-1:0] re_step;
      logic [mpi_pkg::DATA_W-1:0] im_step;
      logic [mpi_pkg::DATA_W-1:0] min_re;
      logic [mpi_pkg::DATA_W-1:0] max_im;
      case (kind)
         VIEW_WHOLE: begin
            // whole set, centre jittered around -0.75
            re_step   = $urandom_range(200000, 240000);
            im_step   = $urandom_range(150000, 190000);
            centre_re = -201326592 + int'($urandom_range(1 << 24)) - (1 << 23);
            centre_im = int'($urandom_range(1 << 24)) - (1 << 23);
            min_re    = centre_re - re_step * HALF_SPAN;
            max_im    = centre_im + im_step * HALF_SPAN;
         end
         VIEW_ZOOM: begin
            re_step   = $urandom_range(8, 512);
            im_step   = re_step;
            centre_re = ZOOM_RE;
            centre_im = ZOOM_IM;
            min_re    = centre_re - re_step * HALF_SPAN;
            max_im    = centre_im + im_step * HALF_SPAN;
         end
         default: begin
            // anything the registers allow, high bits of steps included
            re_step = $urandom() >> $urandom_range(31);
            im_step = $urandom() >> $urandom_range(31);
            min_re  = extreme_or_random();
            max_im  = extreme_or_random();
         end
      endcase
      set_reg(mpi_pkg::REG_MIN_REAL, min_re);
      set_reg(mpi_pkg::REG_REAL_STEP, re_step);
      set_reg(mpi_pkg::REG_MAX_IMAG, max_im);
      set_reg(mpi_pkg::REG_IMAG_STEP, im_step);
      set_reg(mpi_pkg::REG_RED_LEVEL, $urandom());
   endtask

   // reset values read back, corner and inner pixels under the reset viewport
   task automatic test_reset_view();
      for (int i = 0; i < SPARE_REG; i++) check_reg(i);
      send_pixel('0, '0);
      send_pixel('1, '0);
      send_pixel('0, '1);
      send_pixel('1, '1);
      send_pixel(12'haaa, 12'h555);
      send_pixel(12'h555, 12'haaa);
      send_pixel(12'd2048, 12'd1024);
      drain_pixels();
   endtask

   // unit grid from -2: escape boundary and limit cases
   task automatic test_escape_boundary();
      set_reg(mpi_pkg::REG_MIN_REAL, 32'he0000000);    // -2.0
      set_reg(mpi_pkg::REG_REAL_STEP, 32'h10000000);   // 1.0 per column
      set_reg(mpi_pkg::REG_MAX_IMAG, 32'h00000000);
      set_reg(mpi_pkg::REG_IMAG_STEP, 32'h10000000);   // 1.0 per row
      set_reg(mpi_pkg::REG_RED_LEVEL, 32'h000000ff);
      send_pixel(12'd0, 12'd0);   // c = -2 sits on the radius, runs to the limit
      send_pixel(12'd4, 12'd0);   // c = 2, magnitude exactly 4 keeps iterating once
      send_pixel(12'd3, 12'd0);   // c = 1
      send_pixel(12'd5, 12'd0);   // outside before the first step
      send_pixel(12'd2, 12'd0);   // origin
      send_pixel(12'd2, 12'd1);   // c = -i, periodic orbit
      send_pixel(12'd1, 12'd1);   // c = -1 - i
      send_pixel(12'd0, 12'd2);   // c = -2 - 2i
      drain_pixels();
   endtask

   // coordinate saturation, masking of high bits, writes past the register list
   task automatic test_saturation_and_masking();
      set_reg(mpi_pkg::REG_MIN_REAL, 32'h7fffffff);
      set_reg(mpi_pkg::REG_REAL_STEP, 32'hffffffff);
      set_reg(mpi_pkg::REG_MAX_IMAG, 32'h80000000);
      set_reg(mpi_pkg::REG_IMAG_STEP, 32'hffffffff);
      set_reg(mpi_pkg::REG_RED_LEVEL, 32'hffffff5a);
      for (int i = SPARE_REG; i <= LAST_INDEX; i++) set_reg(i, $urandom());
      for (int i = 0; i < SPARE_REG; i++) check_reg(i);
      send_pixel('1, '1);
      send_pixel('0, '0);
      send_pixel(12'd1, 12'h800);
      drain_pixels();
      set_reg(mpi_pkg::REG_MIN_REAL, 32'h80000000);
      set_reg(mpi_pkg::REG_REAL_STEP, 32'h00000000);
      set_reg(mpi_pkg::REG_MAX_IMAG, 32'h7fffffff);
      set_reg(mpi_pkg::REG_IMAG_STEP, 32'h00000000);
      set_reg(mpi_pkg::REG_RED_LEVEL, 32'h00000000);
      send_pixel('1, '1);
      send_pixel(12'h123, 12'hedc);
      drain_pixels();
   endtask

   // random pixels over one viewport of each kind
   task automatic test_random_views(input int unsigned send_pct, input int unsigned stall_pct);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      for (int v = 0; v < VIEW_KINDS; v++) begin
         pick_view(view_kind_type'(v));
         for (int i = 0; i < VIEW_PIXELS; i++) send_pixel(12'($urandom()), 12'($urandom()));
         drain_pixels();
      end
   endtask

   // receiver holds off while pixels keep coming, so the input stalls
   task automatic test_output_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      pick_view(VIEW_WHOLE);
      -> hold_rsp_start;
      for (int i = 0; i < VIEW_KINDS * VIEW_PIXELS; i++) begin
         send_pixel(12'($urandom()), 12'($urandom()));
      end
      drain_pixels();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_reset_view();
      test_escape_boundary();
      test_saturation_and_masking();
      test_random_views(0, 0);
      test_random_views(46, 0);
      test_random_views(0, 46);
      test_random_views(16, 16);
      test_output_backpressure();
      drain_pixels();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/mpi_pkg.sv
rtl/mpi_csr.sv
rtl/mandelbrot_pixel_iterator_core.sv
rtl/mpi_check.sv
test/mandelbrot_pixel_iterator_core_tb.sv
